### src/peer_role_election_fsm_macros.svh
// assertion macros for the peer role election block
`ifndef PEER_ROLE_ELECTION_FSM_MACROS_SVH
`define PEER_ROLE_ELECTION_FSM_MACROS_SVH

`ifndef SYNTHESIS
`define PREFSM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prefsm assertion failed");
`define PREFSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `PREFSM_ASSERT(label, clk, rst_n, (ante) |-> (cons))
`define PREFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `PREFSM_ASSERT(label, clk, rst_n, (ante) |=> (cons))
`else
`define PREFSM_ASSERT(label, clk, rst_n, prop)
`define PREFSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PREFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/prefsm_pkg.sv
// types, codes and helpers shared by the peer role election block
`timescale 1ns / 1ps

package prefsm_pkg;

  localparam int unsigned ADDR_W = 32;

  typedef enum logic [0:0] {
    CFG_LOCAL_ADDR = 1'b0,
    CFG_PEER_ADDR  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_CONFIG = 2'd2,
    OP_PEER   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_MASTER     = 4'b0010,
    ST_SLAVE      = 4'b0100,
    ST_STANDALONE = 4'b1000
  } node_state_e;

  typedef enum logic [1:0] {
    ROLE_UNSET = 2'd0,
    MASTER     = 2'd1,
    SLAVE      = 2'd2,
    STANDALONE = 2'd3
  } role_e;

  localparam logic [1:0] NODE_IDLE       = 2'd0;
  localparam logic [1:0] NODE_MASTER     = 2'd1;
  localparam logic [1:0] NODE_SLAVE      = 2'd2;
  localparam logic [1:0] NODE_STANDALONE = 2'd3;

  localparam logic PEER_DOWN_SET = 1'b1;
  localparam logic ID_OF_MASTER  = 1'b0;
  localparam logic ID_OF_SLAVE   = 1'b1;

  typedef struct packed {
    node_state_e node;
    role_e       cur;
    role_e       prev;
    logic        peer_down;
    logic        own_slave;
  } state_t;

  typedef struct packed {
    logic [1:0] node;
    logic       consumed;
    logic       notified;
    logic [1:0] role_now;
    logic [1:0] role_before;
    logic       status_event;
    logic       local_id_write;
    logic       local_id_slave;
    logic       remote_id_write;
    logic       remote_id_slave;
    logic       own_id_slave;
  } res_t;

  function automatic logic [1:0] node_code(node_state_e st);
    logic [1:0] code;
    case (st)
      ST_MASTER:     code = NODE_MASTER;
      ST_SLAVE:      code = NODE_SLAVE;
      ST_STANDALONE: code = NODE_STANDALONE;
      default:       code = NODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### src/prefsm_evt_if.sv
// event channel: operation and peer status
`timescale 1ns / 1ps

interface prefsm_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       peer_down;

  modport source (output valid, output operation, output peer_down, input ready);
  modport sink (input valid, input operation, input peer_down, output ready);
endinterface

### src/prefsm_res_if.sv
// result channel: node, roles and notification flags
`timescale 1ns / 1ps

interface prefsm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] node;
  logic       consumed;
  logic       notified;
  logic [1:0] role_now;
  logic [1:0] role_before;
  logic       status_event;
  logic       local_id_write;
  logic       local_id_slave;
  logic       remote_id_write;
  logic       remote_id_slave;
  logic       own_id_slave;

  modport source (
    output valid, output node, output consumed, output notified, output role_now,
    output role_before, output status_event, output local_id_write,
    output local_id_slave, output remote_id_write, output remote_id_slave,
    output own_id_slave, input ready
  );
  modport sink (
    input valid, input node, input consumed, input notified, input role_now,
    input role_before, input status_event, input local_id_write,
    input local_id_slave, input remote_id_write, input remote_id_slave,
    input own_id_slave, output ready
  );
endinterface

### src/prefsm_step.sv
// next-state and result logic for one event
`timescale 1ns / 1ps

module prefsm_step (
  input  prefsm_pkg::state_t              state_i,
  input  logic [1:0]                      operation_i,
  input  logic                            peer_down_i,
  input  logic [prefsm_pkg::ADDR_W-1:0]   local_addr_i,
  input  logic [prefsm_pkg::ADDR_W-1:0]   peer_addr_i,
  output prefsm_pkg::state_t              state_o,
  output prefsm_pkg::res_t                res_o
);

  function automatic prefsm_pkg::state_t elect(
    prefsm_pkg::state_t s,
    logic [prefsm_pkg::ADDR_W-1:0] la,
    logic [prefsm_pkg::ADDR_W-1:0] pa
  );
    prefsm_pkg::state_t r;
    r = s;
    if (la != '0 && pa != '0) begin
      if (s.peer_down == prefsm_pkg::PEER_DOWN_SET) begin
        case (s.cur)
          prefsm_pkg::MASTER: begin
            r.prev      = prefsm_pkg::MASTER;
            r.own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          prefsm_pkg::SLAVE: begin
            r.cur       = prefsm_pkg::STANDALONE;
            r.prev      = prefsm_pkg::SLAVE;
            r.own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          prefsm_pkg::STANDALONE: begin
            r.prev      = prefsm_pkg::STANDALONE;
            r.own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          default: ;
        endcase
      end else if (la < pa) begin
        r.prev      = s.cur;
        r.cur       = prefsm_pkg::SLAVE;
        r.own_slave = prefsm_pkg::ID_OF_SLAVE;
      end else if (la > pa) begin
        r.prev      = s.cur;
        r.cur       = prefsm_pkg::MASTER;
        r.own_slave = prefsm_pkg::ID_OF_MASTER;
      end
    end else begin
      r.prev      = s.cur;
      r.cur       = prefsm_pkg::STANDALONE;
      r.own_slave = prefsm_pkg::ID_OF_MASTER;
    end
    case (r.cur)
      prefsm_pkg::MASTER: r.node = prefsm_pkg::ST_MASTER;
      prefsm_pkg::SLAVE:  r.node = prefsm_pkg::ST_SLAVE;
      default:            r.node = prefsm_pkg::ST_STANDALONE;
    endcase
    return r;
  endfunction

  prefsm_pkg::op_e    op;
  prefsm_pkg::state_t nxt;
  prefsm_pkg::state_t peer_upd;
  logic               consumed;
  logic               notify;

  assign op = prefsm_pkg::op_e'(operation_i);

  always_comb begin
    peer_upd           = state_i;
    peer_upd.peer_down = peer_down_i;
    nxt                = state_i;
    consumed           = 1'b0;
    notify             = 1'b0;
    if (state_i.node == prefsm_pkg::ST_IDLE) begin
      if (op == prefsm_pkg::OP_START) begin
        consumed = 1'b1;
        nxt      = elect(state_i, local_addr_i, peer_addr_i);
        notify   = 1'b1;
      end
    end else begin
      case (op)
        prefsm_pkg::OP_PEER: begin
          if (state_i.node == prefsm_pkg::ST_MASTER) begin
            consumed      = 1'b1;
            nxt.peer_down = peer_down_i;
          end else if (state_i.node == prefsm_pkg::ST_SLAVE) begin
            // a slave only reacts to the peer going down
            if (peer_down_i == prefsm_pkg::PEER_DOWN_SET) begin
              consumed      = 1'b1;
              nxt.cur       = prefsm_pkg::STANDALONE;
              nxt.prev      = prefsm_pkg::SLAVE;
              nxt.peer_down = prefsm_pkg::PEER_DOWN_SET;
              nxt.own_slave = prefsm_pkg::ID_OF_MASTER;
              nxt.node      = prefsm_pkg::ST_STANDALONE;
              notify        = 1'b1;
            end
          end else begin
            consumed = 1'b1;
            nxt      = elect(peer_upd, local_addr_i, peer_addr_i);
            notify   = 1'b1;
          end
        end
        prefsm_pkg::OP_STOP: begin
          consumed = 1'b1;
          nxt.node = prefsm_pkg::ST_IDLE;
        end
        prefsm_pkg::OP_CONFIG: begin
          consumed = 1'b1;
          nxt      = elect(state_i, local_addr_i, peer_addr_i);
          notify   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign state_o = nxt;

  always_comb begin
    res_o                 = '0;
    res_o.node            = prefsm_pkg::node_code(nxt.node);
    res_o.consumed        = consumed;
    res_o.notified        = notify;
    res_o.role_now        = nxt.cur;
    res_o.role_before     = nxt.prev;
    res_o.own_id_slave    = nxt.own_slave;
    if (notify) begin
      res_o.status_event    = (nxt.cur != nxt.prev);
      res_o.local_id_write  = (local_addr_i != '0) || (nxt.cur == prefsm_pkg::STANDALONE);
      res_o.local_id_slave  = (nxt.cur == prefsm_pkg::SLAVE);
      res_o.remote_id_write = (peer_addr_i != '0);
      res_o.remote_id_slave = (nxt.cur == prefsm_pkg::MASTER);
    end
  end

endmodule

### src/peer_role_election_fsm.sv
// top level of the two-node peer role election block
//
//   channel  dir  handshake      payload
//   evt_i    in   valid/ready    operation, peer_down
//   res_o    out  valid/ready    node, consumed, notified, roles, id flags
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// one item per cycle while the result side is ready; an item that is taken
// passes through the event register and then the result register
// the event register feeds the step logic, which updates the node state
// and loads the result register in the same cycle
// reset sets the node to idle and clears roles, peer flag, own id and both addresses
// a stalled result holds the event register, which then drops ready
`timescale 1ns / 1ps
`include "peer_role_election_fsm_macros.svh"

module peer_role_election_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [prefsm_pkg::ADDR_W-1:0] cfg_wdata_i,
  prefsm_evt_if.sink                    evt_i,
  prefsm_res_if.source                  res_o
);

  logic [prefsm_pkg::ADDR_W-1:0] local_addr_q;
  logic [prefsm_pkg::ADDR_W-1:0] peer_addr_q;

  logic               evt_valid_q;
  logic [1:0]         op_q;
  logic               down_q;

  prefsm_pkg::state_t state_q;
  prefsm_pkg::state_t state_d;
  prefsm_pkg::res_t   res_d;
  prefsm_pkg::res_t   res_q;
  logic               res_valid_q;
  logic               fire;

  assign fire        = evt_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !evt_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
      peer_addr_q  <= '0;
    end else if (cfg_we_i) begin
      case (prefsm_pkg::cfg_reg_e'(cfg_idx_i))
        prefsm_pkg::CFG_LOCAL_ADDR: local_addr_q <= cfg_wdata_i;
        prefsm_pkg::CFG_PEER_ADDR:  peer_addr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      op_q   <= evt_i.operation;
      down_q <= evt_i.peer_down;
    end
  end

  prefsm_step u_step (
    .state_i      (state_q),
    .operation_i  (op_q),
    .peer_down_i  (down_q),
    .local_addr_i (local_addr_q),
    .peer_addr_i  (peer_addr_q),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.node      <= prefsm_pkg::ST_IDLE;
      state_q.cur       <= prefsm_pkg::ROLE_UNSET;
      state_q.prev      <= prefsm_pkg::ROLE_UNSET;
      state_q.peer_down <= 1'b0;
      state_q.own_slave <= prefsm_pkg::ID_OF_MASTER;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.node            = res_q.node;
  assign res_o.consumed        = res_q.consumed;
  assign res_o.notified        = res_q.notified;
  assign res_o.role_now        = res_q.role_now;
  assign res_o.role_before     = res_q.role_before;
  assign res_o.status_event    = res_q.status_event;
  assign res_o.local_id_write  = res_q.local_id_write;
  assign res_o.local_id_slave  = res_q.local_id_slave;
  assign res_o.remote_id_write = res_q.remote_id_write;
  assign res_o.remote_id_slave = res_q.remote_id_slave;
  assign res_o.own_id_slave    = res_q.own_id_slave;

  // an unhandled event leaves the node state untouched
  `PREFSM_ASSERT_NEXT(a_unhandled_keeps_state, clk_i, rst_ni,
                      fire && !res_d.consumed, $stable(state_q))
  `PREFSM_ASSERT_NEXT(a_fire_loads_result, clk_i, rst_ni, fire, res_valid_q)
  `PREFSM_ASSERT_IMPL(a_notify_needs_consume, clk_i, rst_ni,
                      res_valid_q && res_q.notified, res_q.consumed)
  `PREFSM_ASSERT_IMPL(a_idle_no_notify, clk_i, rst_ni,
                      res_valid_q && (res_q.node == prefsm_pkg::NODE_IDLE), !res_q.notified)
  // the result shown matches the state it left behind
  `PREFSM_ASSERT_NEXT(a_result_matches_state, clk_i, rst_ni,
                      fire, res_q.role_now == state_q.cur)

endmodule

### tb/sv/prefsm_election_checker.sv
// checker for the peer role election block: tracks roles, predicts each result and compares
`timescale 1ns / 1ps

module prefsm_election_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [prefsm_pkg::ADDR_W-1:0] cfg_wdata_i,
  prefsm_evt_if                         evt,
  prefsm_res_if                         res,
  output int                            n_fail_o,
  output int                            n_pending_o
);

  logic [prefsm_pkg::ADDR_W-1:0] loc_addr;
  logic [prefsm_pkg::ADDR_W-1:0] peer_addr;
  logic [1:0]                    node_now;
  prefsm_pkg::role_e             cur_role;
  prefsm_pkg::role_e             prev_role;
  logic                          peer_dn;
  logic                          own_slave;

  prefsm_pkg::res_t expected_status[$];
  int               n_results;

  task automatic report_failure(input string msg);
    n_fail_o++;
    $display("mismatch: %s", msg);
  endtask

  // election at the decision point, returns the node to enter
  function automatic logic [1:0] elect_node();
    logic [1:0] code;
    if (loc_addr != '0 && peer_addr != '0) begin
      if (peer_dn == prefsm_pkg::PEER_DOWN_SET) begin
        case (cur_role)
          prefsm_pkg::MASTER: begin
            prev_role = prefsm_pkg::MASTER;
            own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          prefsm_pkg::SLAVE: begin
            cur_role  = prefsm_pkg::STANDALONE;
            prev_role = prefsm_pkg::SLAVE;
            own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          prefsm_pkg::STANDALONE: begin
            prev_role = prefsm_pkg::STANDALONE;
            own_slave = prefsm_pkg::ID_OF_MASTER;
          end
          default: ;
        endcase
      end else if (loc_addr < peer_addr) begin
        prev_role = cur_role;
        cur_role  = prefsm_pkg::SLAVE;
        own_slave = prefsm_pkg::ID_OF_SLAVE;
      end else if (loc_addr > peer_addr) begin
        prev_role = cur_role;
        cur_role  = prefsm_pkg::MASTER;
        own_slave = prefsm_pkg::ID_OF_MASTER;
      end
    end else begin
      prev_role = cur_role;
      cur_role  = prefsm_pkg::STANDALONE;
      own_slave = prefsm_pkg::ID_OF_MASTER;
    end
    case (cur_role)
      prefsm_pkg::MASTER: code = prefsm_pkg::NODE_MASTER;
      prefsm_pkg::SLAVE:  code = prefsm_pkg::NODE_SLAVE;
      default:            code = prefsm_pkg::NODE_STANDALONE;
    endcase
    return code;
  endfunction

  function automatic prefsm_pkg::res_t predict_election(input prefsm_pkg::op_e op,
                                                        input logic down);
    prefsm_pkg::res_t r;
    logic announce;
    r        = '0;
    announce = 1'b0;
    if (node_now == prefsm_pkg::NODE_IDLE) begin
      if (op == prefsm_pkg::OP_START) begin
        r.consumed = 1'b1;
        node_now   = elect_node();
        announce   = 1'b1;
      end
    end else begin
      case (op)
        prefsm_pkg::OP_PEER: begin
          if (node_now == prefsm_pkg::NODE_MASTER) begin
            r.consumed = 1'b1;
            peer_dn    = down;
          end else if (node_now == prefsm_pkg::NODE_SLAVE) begin
            // a slave only reacts to the peer going down
            if (down == prefsm_pkg::PEER_DOWN_SET) begin
              r.consumed = 1'b1;
              cur_role   = prefsm_pkg::STANDALONE;
              prev_role  = prefsm_pkg::SLAVE;
              peer_dn    = prefsm_pkg::PEER_DOWN_SET;
              own_slave  = prefsm_pkg::ID_OF_MASTER;
              node_now   = prefsm_pkg::NODE_STANDALONE;
              announce   = 1'b1;
            end
          end else begin
            r.consumed = 1'b1;
            peer_dn    = down;
            node_now   = elect_node();
            announce   = 1'b1;
          end
        end
        prefsm_pkg::OP_STOP: begin
          r.consumed = 1'b1;
          node_now   = prefsm_pkg::NODE_IDLE;
        end
        prefsm_pkg::OP_CONFIG: begin
          r.consumed = 1'b1;
          node_now   = elect_node();
          announce   = 1'b1;
        end
        default: ;
      endcase
    end
    if (announce) begin
      r.notified        = 1'b1;
      r.status_event    = (cur_role != prev_role);
      r.local_id_write  = (loc_addr != '0) || (cur_role == prefsm_pkg::STANDALONE);
      r.local_id_slave  = (cur_role == prefsm_pkg::SLAVE);
      r.remote_id_write = (peer_addr != '0);
      r.remote_id_slave = (cur_role == prefsm_pkg::MASTER);
    end
    r.node         = node_now;
    r.role_now     = cur_role;
    r.role_before  = prev_role;
    r.own_id_slave = own_slave;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prefsm_pkg::res_t seen;
    prefsm_pkg::res_t want;
    if (!rst_ni) begin
      loc_addr  = '0;
      peer_addr = '0;
      node_now  = prefsm_pkg::NODE_IDLE;
      cur_role  = prefsm_pkg::ROLE_UNSET;
      prev_role = prefsm_pkg::ROLE_UNSET;
      peer_dn   = 1'b0;
      own_slave = prefsm_pkg::ID_OF_MASTER;
      expected_status.delete();
      n_results = 0;
      n_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == prefsm_pkg::CFG_LOCAL_ADDR) loc_addr = cfg_wdata_i;
        else peer_addr = cfg_wdata_i;
      end
      if (res.valid && res.ready) begin
        seen.node            = res.node;
        seen.consumed        = res.consumed;
        seen.notified        = res.notified;
        seen.role_now        = res.role_now;
        seen.role_before     = res.role_before;
        seen.status_event    = res.status_event;
        seen.local_id_write  = res.local_id_write;
        seen.local_id_slave  = res.local_id_slave;
        seen.remote_id_write = res.remote_id_write;
        seen.remote_id_slave = res.remote_id_slave;
        seen.own_id_slave    = res.own_id_slave;
        if (expected_status.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no event pending", n_results));
        end else begin
          want = expected_status.pop_front();
          if (seen.node !== want.node)
            report_failure($sformatf("result %0d node %0h, expected %0h",
                                     n_results, seen.node, want.node));
          if (seen.consumed !== want.consumed)
            report_failure($sformatf("result %0d consumed %0h, expected %0h",
                                     n_results, seen.consumed, want.consumed));
          if (seen.notified !== want.notified)
            report_failure($sformatf("result %0d notified %0h, expected %0h",
                                     n_results, seen.notified, want.notified));
          if (seen.role_now !== want.role_now)
            report_failure($sformatf("result %0d role_now %0h, expected %0h",
                                     n_results, seen.role_now, want.role_now));
          if (seen.role_before !== want.role_before)
            report_failure($sformatf("result %0d role_before %0h, expected %0h",
                                     n_results, seen.role_before, want.role_before));
          if (seen.status_event !== want.status_event)
            report_failure($sformatf("result %0d status_event %0h, expected %0h",
                                     n_results, seen.status_event, want.status_event));
          if (seen.local_id_write !== want.local_id_write)
            report_failure($sformatf("result %0d local_id_write %0h, expected %0h",
                                     n_results, seen.local_id_write, want.local_id_write));
          if (seen.local_id_slave !== want.local_id_slave)
            report_failure($sformatf("result %0d local_id_slave %0h, expected %0h",
                                     n_results, seen.local_id_slave, want.local_id_slave));
          if (seen.remote_id_write !== want.remote_id_write)
            report_failure($sformatf("result %0d remote_id_write %0h, expected %0h",
                                     n_results, seen.remote_id_write, want.remote_id_write));
          if (seen.remote_id_slave !== want.remote_id_slave)
            report_failure($sformatf("result %0d remote_id_slave %0h, expected %0h",
                                     n_results, seen.remote_id_slave, want.remote_id_slave));
          if (seen.own_id_slave !== want.own_id_slave)
            report_failure($sformatf("result %0d own_id_slave %0h, expected %0h",
                                     n_results, seen.own_id_slave, want.own_id_slave));
        end
        n_results++;
      end
      if (evt.valid && evt.ready)
        expected_status.push_back(predict_election(prefsm_pkg::op_e'(evt.operation),
                                                   evt.peer_down));
      n_pending_o <= expected_status.size();
    end
  end

endmodule

### tb/sv/tb.sv
// testbench top: clock, reset, event and address stimulus, result stalls and verdict
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [0:0]                    cfg_idx_i;
  logic [prefsm_pkg::ADDR_W-1:0] cfg_wdata_i;

  int   n_fail;
  int   n_pending;
  logic idle_on;
  int   hold_asked;
  int   n_sent;
  int   n_settings;
  int   cycle_count;

  prefsm_evt_if evt ();
  prefsm_res_if res ();

  peer_role_election_fsm i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt),
    .res_o       (res)
  );

  prefsm_election_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt         (evt),
    .res         (res),
    .n_fail_o    (n_fail),
    .n_pending_o (n_pending)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding", n_pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_event(input prefsm_pkg::op_e op, input logic down);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid     <= 1'b1;
    evt.operation <= op;
    evt.peer_down <= down;
    do @(posedge clk_i); while (!evt.ready);
    n_sent++;
  endtask

  task automatic wait_drained();
    evt.valid <= 1'b0;
    do @(posedge clk_i); while (n_pending != 0);
  endtask

  // addresses only change while the block has nothing in flight
  task automatic set_addresses(input logic [prefsm_pkg::ADDR_W-1:0] loc,
                               input logic [prefsm_pkg::ADDR_W-1:0] peer);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= prefsm_pkg::CFG_LOCAL_ADDR;
    cfg_wdata_i <= loc;
    @(posedge clk_i);
    cfg_idx_i   <= prefsm_pkg::CFG_PEER_ADDR;
    cfg_wdata_i <= peer;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int n, input bit no_gaps);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_on <= no_gaps ? 1'b0 : ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 5) send_event(prefsm_pkg::OP_START, 1'($urandom_range(0, 1)));
      else if (pick < 8) send_event(prefsm_pkg::OP_STOP, 1'($urandom_range(0, 1)));
      else if (pick < 13) send_event(prefsm_pkg::OP_CONFIG, 1'($urandom_range(0, 1)));
      else send_event(prefsm_pkg::OP_PEER, 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int stall;
    int hold_served;
    res.ready   = 1'b0;
    hold_served = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  initial begin
    logic [prefsm_pkg::ADDR_W-1:0] same_addr;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = prefsm_pkg::CFG_LOCAL_ADDR;
    cfg_wdata_i   = '0;
    evt.valid     = 1'b0;
    evt.operation = prefsm_pkg::OP_START;
    evt.peer_down = 1'b0;
    idle_on       = 1'b1;
    hold_asked    = 0;
    n_sent        = 0;
    n_settings    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // equal addresses from reset: role stays unset, node goes standalone
    set_addresses(32'h5, 32'h5);
    send_event(prefsm_pkg::OP_PEER, 1'b1);
    send_event(prefsm_pkg::OP_STOP, 1'b0);
    send_event(prefsm_pkg::OP_CONFIG, 1'b0);
    send_event(prefsm_pkg::OP_START, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b1);
    send_event(prefsm_pkg::OP_PEER, 1'b0);
    send_event(prefsm_pkg::OP_START, 1'b1);
    send_event(prefsm_pkg::OP_STOP, 1'b0);

    // higher local address: master, peer down keeps master
    set_addresses(32'hFFFF_FFFF, 32'h1);
    send_event(prefsm_pkg::OP_START, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b1);
    send_event(prefsm_pkg::OP_CONFIG, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b0);
    send_event(prefsm_pkg::OP_STOP, 1'b1);

    // lower local address: slave, ignores peer up, drops to standalone on peer down
    set_addresses(32'h1, 32'hFFFF_FFFF);
    send_event(prefsm_pkg::OP_START, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b1);
    send_event(prefsm_pkg::OP_CONFIG, 1'b0);
    send_event(prefsm_pkg::OP_PEER, 1'b0);

    // local address absent
    set_addresses(32'h0, 32'h1234_5678);
    send_event(prefsm_pkg::OP_CONFIG, 1'b0);
    send_event(prefsm_pkg::OP_STOP, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_addresses(32'h0, 32'h0);
        1: set_addresses($urandom, 32'h0);
        2: set_addresses(32'h0, $urandom);
        3: set_addresses(32'h1, 32'hFFFF_FFFF);
        4: set_addresses(32'hFFFF_FFFF, 32'h1);
        5: begin
          same_addr = $urandom;
          set_addresses(same_addr, same_addr);
        end
        6: set_addresses($urandom, $urandom);
        default: set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      endcase
      if (p == 4) begin
        // back-to-back items against a held result side
        hold_asked <= hold_asked + 1;
        run_random(40, 1'b1);
      end
      run_random(200, 1'b0);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d events over %0d address settings, all ops with peer up and down",
             n_sent, n_settings);
    $display("result side held off once for %0d cycles while events kept arriving",
             HOLD_CYCLES);
    if (n_fail == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
